[hw/rtl/agu_pkg.sv]
`default_nettype none
package agu_pkg;

   localparam int QueueDepth = 4;

   localparam logic [1:0] KIND_ACCESS    = 2'd0;
   localparam logic [1:0] KIND_WRITEBACK = 2'd1;
   localparam logic [1:0] KIND_STATUS    = 2'd2;
   localparam logic [1:0] KIND_NONE      = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_UNIMPL = 2'd1;
   localparam logic [1:0] ST_MALF   = 2'd2;

   localparam logic [1:0] EXT_ZERO = 2'd0;
   localparam logic [1:0] EXT_S64  = 2'd1;
   localparam logic [1:0] EXT_S32  = 2'd2;

   localparam logic [2:0] GRP_EXCL  = 3'd2;
   localparam logic [2:0] GRP_LIT   = 3'd3;
   localparam logic [2:0] GRP_PAIR  = 3'd5;
   localparam logic [2:0] GRP_REG   = 3'd7;

   typedef struct packed {
      logic [31:0] instruction;
      logic [63:0] base_value;
      logic [63:0] index_value;
      logic [63:0] program_counter;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] address;
      logic [1:0]  size_log2;
      logic        is_write;
      logic [4:0]  reg_num;
      logic        reg_is_vector;
      logic        lane;
      logic [1:0]  extend_mode;
      logic        clear_vector;
      logic [63:0] value;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // One classified instruction as handed from decode to the sequencer.
   typedef struct packed {
      logic [1:0]  bad;          // non-zero: single no-action item with this status
      logic        two_elem;     // pair form: second element follows
      logic        split;        // each element is a quadword, two halves
      logic [63:0] addr;
      logic [2:0]  esz;          // element size log2, 0..4
      logic        wr;
      logic        vec;
      logic [1:0]  ext;
      logic [4:0]  rt;
      logic [4:0]  rt2;
      logic        do_wb;
      logic [4:0]  rn;
      logic [63:0] wb_value;
      logic        do_stat;
      logic        no_access;    // failed store-exclusive: status item only
      logic [4:0]  rs;
      logic        stat_value;
   } job_type;

   function automatic logic [63:0] sext(input logic [63:0] v, input int bits);
      logic [63:0] r;
      r = v;
      for (int i = 0; i < 64; i++) begin
         if (i >= bits) r[i] = v[bits-1];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/agu_decode.sv]
`default_nettype none
module agu_decode (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  agu_pkg::req_type req_data,
   output logic             job_valid,
   output agu_pkg::job_type job,
   input  wire              job_stall
);

   logic        armed_ff, armed_in;
   logic [63:0] mon_ff, mon_in;
   logic        valid_ff, valid_in;
   agu_pkg::job_type job_ff, job_in;
   logic        take;

   logic [31:0] w;
   logic [2:0]  op1;
   logic        vec;
   logic [1:0]  hi, opc, it, mode;
   logic [63:0] base, off, idx_ext, imm9, a;
   logic [2:0]  scale;
   logic        ok;
   logic [3:0]  so;

   assign req_stall = valid_ff && job_stall;
   assign take      = req_valid && !req_stall;
   assign job_valid = valid_ff;
   assign job       = job_ff;

   // Decode one instruction into an access plan.
   always_comb begin
      w    = req_data.instruction;
      base = req_data.base_value;
      op1  = w[29:27];
      vec  = w[26];
      hi   = w[31:30];
      opc  = w[23:22];
      it   = w[11:10];
      mode = w[24:23];
      armed_in = armed_ff;
      mon_in   = mon_ff;
      job_in = '0;
      job_in.rt  = w[4:0];
      job_in.rt2 = w[14:10];
      job_in.rn  = w[9:5];
      job_in.rs  = w[20:16];
      off = '0; idx_ext = '0; imm9 = '0; a = '0; scale = '0; ok = 1'b0;
      so = {hi, opc};
      case (op1)
         agu_pkg::GRP_PAIR: begin
            if (mode == 2'd0 || hi == 2'd3 || (!vec && !w[22] && hi == 2'd1)) begin
               job_in.bad = agu_pkg::ST_UNIMPL;
            end else begin
               scale = vec ? 3'(hi) + 3'd2 : (hi[1] ? 3'd3 : 3'd2);
               off = agu_pkg::sext({57'd0, w[21:15]}, 7) << scale;
               job_in.addr = (mode[1]) ? base + off : base;
               job_in.esz = scale;
               job_in.split = (scale == 3'd4);
               job_in.two_elem = 1'b1;
               job_in.wr = !w[22];
               job_in.vec = vec;
               job_in.ext = (!vec && w[22] && hi == 2'd1) ? agu_pkg::EXT_S64
                                                          : agu_pkg::EXT_ZERO;
               job_in.do_wb = mode[0];
               job_in.wb_value = base + off;
            end
         end
         agu_pkg::GRP_LIT: begin
            if (w[24]) begin
               job_in.bad = agu_pkg::ST_UNIMPL;
            end else if (hi == 2'd3) begin
               job_in.bad = agu_pkg::ST_UNIMPL;
            end else begin
               job_in.addr = req_data.program_counter
                  + (agu_pkg::sext({45'd0, w[23:5]}, 19) << 2);
               job_in.vec = vec;
               if (vec) begin
                  job_in.esz = 3'(hi) + 3'd2;
                  job_in.split = (hi == 2'd2);
               end else begin
                  job_in.esz = (hi == 2'd1) ? 3'd3 : 3'd2;
                  job_in.ext = (hi == 2'd2) ? agu_pkg::EXT_S64 : agu_pkg::EXT_ZERO;
               end
            end
         end
         agu_pkg::GRP_EXCL: begin
            job_in.addr = base;
            job_in.esz = {1'b0, hi};
            job_in.wr = !w[22];
            if (!w[23] && w[22]) begin
               armed_in = 1'b1;
               mon_in = base;
            end else if (!w[23]) begin
               job_in.do_stat = 1'b1;
               if (armed_ff && mon_ff == base) job_in.stat_value = 1'b0;
               else begin
                  job_in.stat_value = 1'b1;
                  job_in.no_access = 1'b1;
               end
               armed_in = 1'b0;
            end
         end
         agu_pkg::GRP_REG: begin
            // Address by form, then check the size/opc allocation.
            scale = (vec && hi == 2'd0 && opc[1]) ? 3'd4 : {1'b0, hi};
            case (w[15:13])
               3'd0: idx_ext = {56'd0, req_data.index_value[7:0]};
               3'd1: idx_ext = {48'd0, req_data.index_value[15:0]};
               3'd2: idx_ext = {32'd0, req_data.index_value[31:0]};
               3'd4: idx_ext = agu_pkg::sext(req_data.index_value, 8);
               3'd5: idx_ext = agu_pkg::sext(req_data.index_value, 16);
               3'd6: idx_ext = agu_pkg::sext(req_data.index_value, 32);
               default: idx_ext = req_data.index_value;
            endcase
            imm9 = agu_pkg::sext({55'd0, w[20:12]}, 9);
            if (w[24]) a = base + ({52'd0, w[21:10]} << scale);
            else if (it == 2'd2) a = base + (w[12] ? idx_ext << scale : idx_ext);
            else if (it == 2'd1) a = base;
            else a = base + imm9;
            job_in.addr = a;
            job_in.vec = vec;
            job_in.esz = {1'b0, hi};
            if (vec) begin
               ok = 1'b1;
               if (opc == 2'd1) job_in.wr = 1'b0;
               else if (opc == 2'd0) job_in.wr = 1'b1;
               else if (hi == 2'd0) begin
                  job_in.esz = 3'd4;
                  job_in.split = 1'b1;
                  job_in.wr = (opc == 2'd2);
               end else ok = 1'b0;
            end else begin
               ok = 1'b1;
               case (so)
                  4'h0, 4'h4, 4'h8, 4'hC: job_in.wr = 1'b1;
                  4'h1, 4'h5, 4'h9, 4'hD: job_in.ext = agu_pkg::EXT_ZERO;
                  4'h2, 4'h6, 4'hA: job_in.ext = agu_pkg::EXT_S64;
                  4'h3, 4'h7: begin
                     job_in.ext = agu_pkg::EXT_S32;
                  end
                  default: ok = 1'b0;
               endcase
            end
            if (!w[24] && it == 2'd2 && !w[21]) job_in.bad = agu_pkg::ST_MALF;
            else if (!ok) job_in.bad = agu_pkg::ST_UNIMPL;
            else if (!w[24] && it[0]) begin
               job_in.do_wb = 1'b1;
               job_in.wb_value = base + imm9;
            end
         end
         default: job_in.bad = agu_pkg::ST_UNIMPL;
      endcase
      if (!take) begin
         armed_in = armed_ff;
         mon_in = mon_ff;
      end
      valid_in = take ? 1'b1 : (valid_ff && job_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         mon_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
         mon_ff   <= mon_in;
         valid_ff <= valid_in;
      end
      if (take) job_ff <= job_in;
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && job_stall |=> valid_ff && $stable(job_ff))
      else $error("decode output lost while stalled");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> !req_stall)
      else $error("decode stalls while empty");
   a_disarm: assert property (@(posedge clock) disable iff (reset)
      $past(take) && $past(job_in.do_stat) |-> !armed_ff)
      else $error("store exclusive left monitor armed");
`endif

endmodule
`default_nettype wire

[hw/rtl/agu_queue.sv]
`default_nettype none
module agu_queue #(
   parameter int Depth = agu_pkg::QueueDepth
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_stall,
   input  agu_pkg::job_type in_job,
   output logic             out_valid,
   output agu_pkg::job_type out_job,
   input  wire              out_stall
);

   localparam int AW = $clog2(Depth);

   agu_pkg::job_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_stall  = (cnt_ff == (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_job   = mem_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // Pointers wrap around the ring of entries.
   always_comb begin
      wp_in  = push ? ((wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? ((rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end

`ifndef SYNTH
   a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(Depth))
      else $error("queue overflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count wrong on push");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !pop)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[hw/rtl/agu_issue.sv]
`default_nettype none
module agu_issue (
   input  wire              clock,
   input  wire              reset,
   input  wire              job_valid,
   input  agu_pkg::job_type job,
   output logic             job_stall,
   output logic             rsp_valid,
   output agu_pkg::rsp_type rsp_data,
   input  wire              rsp_stall
);

   // Step: 0..3 access beats (element, half), then the trailing item.
   logic [2:0]  step_ff, step_in;
   logic        ovalid_ff, ovalid_in;
   agu_pkg::rsp_type out_ff, out_in;
   logic        emit, done, n_acc_last, is_tail;
   logic [2:0]  n_acc;
   logic        elem, half;
   logic [63:0] ebase;

   assign rsp_valid = ovalid_ff;
   assign rsp_data  = out_ff;
   assign emit = job_valid && (!ovalid_ff || !rsp_stall);

   always_comb begin
      if (job.bad != agu_pkg::ST_OK || job.no_access) n_acc = 3'd0;
      else n_acc = 3'd1 + 3'(job.split) + (job.two_elem ? 3'd1 + 3'(job.split) : 3'd0);
      is_tail = (step_ff >= n_acc);
      n_acc_last = (step_ff + 3'd1 == n_acc) && !job.do_wb && !job.do_stat;
      elem = job.split ? step_ff[1] : step_ff[0];
      half = job.split & step_ff[0];
      ebase = elem ? job.addr + (64'd1 << job.esz) : job.addr;
      out_in = '0;
      if (job.bad != agu_pkg::ST_OK) begin
         out_in.kind = agu_pkg::KIND_NONE;
         out_in.status = job.bad;
         out_in.last = 1'b1;
      end else if (!is_tail) begin
         out_in.kind = agu_pkg::KIND_ACCESS;
         out_in.address = half ? ebase + 64'd8 : ebase;
         out_in.size_log2 = job.split ? 2'd3 : job.esz[1:0];
         out_in.is_write = job.wr;
         out_in.reg_num = elem ? job.rt2 : job.rt;
         out_in.reg_is_vector = job.vec;
         out_in.lane = half;
         out_in.extend_mode = job.wr ? agu_pkg::EXT_ZERO : job.ext;
         out_in.clear_vector = job.vec && !job.wr && !half;
         out_in.last = n_acc_last;
      end else if (job.do_wb) begin
         out_in.kind = agu_pkg::KIND_WRITEBACK;
         out_in.reg_num = job.rn;
         out_in.value = job.wb_value;
         out_in.last = 1'b1;
      end else begin
         out_in.kind = agu_pkg::KIND_STATUS;
         out_in.reg_num = job.rs;
         out_in.value = {63'd0, job.stat_value};
         out_in.last = 1'b1;
      end
      done = emit && out_in.last;
      step_in = done ? 3'd0 : (emit ? step_ff + 3'd1 : step_ff);
      ovalid_in = emit ? 1'b1 : (ovalid_ff && rsp_stall);
   end

   assign job_stall = !done;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         ovalid_ff <= ovalid_in;
      end
      if (emit) out_ff <= out_in;
   end

`ifndef SYNTH
   a_step: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'd4)
      else $error("issue step out of range");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      done |=> step_ff == 3'd0)
      else $error("step not cleared after last item");
   a_keep: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && rsp_stall |=> ovalid_ff && $stable(out_ff))
      else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

[hw/rtl/aarch64_load_store_agu.sv]
`default_nettype none
// Address generation for AArch64 loads and stores. Each instruction is decoded and
// registered into a queue of four entries; the issue stage emits one result item per
// cycle while the output is not stalled: one to four accesses (pairs and quadwords split
// into doubleword halves), then a base writeback or exclusive status item where needed; a
// rejected instruction gives one status-only item; pairs are paced by the issue output.
module aarch64_load_store_agu #(
   parameter int QueueDepth = agu_pkg::QueueDepth
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  agu_pkg::req_type req_data,
   output logic             rsp_valid,
   output agu_pkg::rsp_type rsp_data,
   input  wire              rsp_stall
);

   logic d_valid, d_stall, q_valid, q_stall;
   agu_pkg::job_type d_job, q_job;

   agu_decode u_dec (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .job_valid(d_valid), .job(d_job), .job_stall(d_stall)
   );

   agu_queue #(.Depth(QueueDepth)) u_q (
      .clock, .reset, .in_valid(d_valid), .in_stall(d_stall), .in_job(d_job),
      .out_valid(q_valid), .out_job(q_job), .out_stall(q_stall)
   );

   agu_issue u_iss (
      .clock, .reset, .job_valid(q_valid), .job(q_job), .job_stall(q_stall),
      .rsp_valid, .rsp_data, .rsp_stall
   );

endmodule
`default_nettype wire
